// ----- hdl/imu_shake_direction_detector_macros.svh -----
// Assertion macros for the shake direction detector.
`ifndef IMU_SHAKE_DIRECTION_DETECTOR_MACROS_SVH
`define IMU_SHAKE_DIRECTION_DETECTOR_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ISDD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ISDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/isdd_pkg.sv -----
package isdd_pkg;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ROOT = 6'b000100,
        S_UPD  = 6'b001000,
        S_DEC  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd4;

    localparam logic [15:0] DECAY_RST    = 16'd58982;
    localparam logic [23:0] THRESH_RST   = 24'd2000;
    localparam logic [15:0] WINDOW_RST   = 16'd150;
    localparam logic [15:0] TIMEOUT_RST  = 16'd500;
    localparam logic [15:0] COOLDOWN_RST = 16'd400;

    localparam logic signed [1:0] DIR_NONE  = 2'sb00;
    localparam logic signed [1:0] DIR_RIGHT = 2'sb01;
    localparam logic signed [1:0] DIR_LEFT  = 2'sb11;

endpackage

// ----- hdl/imu_shake_direction_detector.sv -----
// Each sample passes S_MUL (the shared multiplier forms the three squared differences,
// then the decayed intensity), S_ROOT (bit-serial square root), S_UPD, S_DEC and S_OUT;
// the first sample after reset, which has no previous sample, goes straight to S_DEC.
// Input stalls outside S_IDLE: a sample is taken only once the last result is loaded.
// One held result does not block input; output stall then delays the next result load.
// Reset: synchronous active-low i_rst_n clears state and loads register defaults.
`include "imu_shake_direction_detector_macros.svh"

module imu_shake_direction_detector
    import isdd_pkg::*;
#(
    parameter int ACCEL_WIDTH     = 16,
    parameter int INTENSITY_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [ACCEL_WIDTH-1:0] i_accel_x,
    input  logic signed [ACCEL_WIDTH-1:0] i_accel_y,
    input  logic signed [ACCEL_WIDTH-1:0] i_accel_z,
    input  logic [31:0]                   i_time_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [1:0]             o_direction,
    output logic                          o_detecting
);

    localparam int A    = ACCEL_WIDTH;
    localparam int IW   = INTENSITY_WIDTH;
    localparam int MA   = (A + 1 > IW) ? A + 1 : IW;
    localparam int MB   = (A + 1 > 16) ? A + 1 : 16;
    localparam int PW   = MA + MB;
    localparam int SQ_W = 2 * A + 2;
    localparam int RT_W = A + 1;
    localparam int CNT_W = $clog2(RT_W);
    localparam int SUM_W = ((IW > RT_W) ? IW : RT_W) + 1;
    localparam int CW    = (IW + 4 > 26) ? IW + 4 : 26;
    localparam logic [CNT_W-1:0] RT_LAST  = CNT_W'(RT_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);

    t_state r_state;

    logic [15:0] r_decay;
    logic [23:0] r_thresh;
    logic [15:0] r_window;
    logic [15:0] r_timeout;
    logic [15:0] r_cooldown;

    logic                r_have_prev;
    logic signed [A-1:0] r_px, r_py, r_pz;
    logic signed [A-1:0] r_ax, r_ay, r_az;
    logic [31:0]         r_now;
    logic [IW-1:0]       r_intensity;
    logic                r_phase;
    logic [31:0]         r_win_start;
    logic signed [31:0]  r_xsum;
    logic [31:0]         r_cool_until;

    logic [CNT_W-1:0]  r_cnt;
    logic [SQ_W-1:0]   r_sq;
    logic [IW-1:0]     r_decayed;
    logic [RT_W+1:0]   r_rem;
    logic [RT_W-1:0]   r_root;
    logic signed [1:0] r_dir_pend;

    logic              r_out_valid;
    logic signed [1:0] r_direction;
    logic              r_detecting;

    // shared multiplier operands
    logic signed [A:0] dx, dy, dz, d_sel;
    logic [A:0]        d_abs;
    logic [MA-1:0]     mul_a;
    logic [MB-1:0]     mul_b;
    logic [PW-1:0]     prod;

    // square root step
    logic [RT_W+3:0] rem_sh, trial;
    logic            root_bit;

    // update and decide
    logic [SUM_W-1:0]   upd_sum;
    logic [CW-1:0]      int10, thr_ext, thr3, int_ext;
    logic [31:0]        elapsed;
    logic signed [32:0] xs_wide;
    logic signed [31:0] xs_sat;

    logic in_xfer, out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_direction = r_direction;
    assign o_detecting = r_detecting;

    always_comb begin
        dx = {r_ax[A-1], r_ax} - {r_px[A-1], r_px};
        dy = {r_ay[A-1], r_ay} - {r_py[A-1], r_py};
        dz = {r_az[A-1], r_az} - {r_pz[A-1], r_pz};
        case (r_cnt[1:0])
            2'd0:    d_sel = dx;
            2'd1:    d_sel = dy;
            default: d_sel = dz;
        endcase
        d_abs = d_sel[A] ? (A + 1)'(-d_sel) : (A + 1)'(d_sel);
        if (r_cnt[1:0] == 2'd3) begin
            mul_a = MA'(r_intensity);
            mul_b = MB'(r_decay);
        end else begin
            mul_a = MA'(d_abs);
            mul_b = MB'(d_abs);
        end
        prod = PW'(mul_a) * PW'(mul_b);
    end

    always_comb begin
        rem_sh   = {r_rem, r_sq[SQ_W-1:SQ_W-2]};
        trial    = (RT_W + 4)'({r_root, 2'b01});
        root_bit = (rem_sh >= trial);
    end

    always_comb begin
        upd_sum  = SUM_W'(r_decayed) + SUM_W'(r_root);
        int_ext  = CW'(r_intensity);
        int10    = (int_ext << 3) + (int_ext << 1);
        thr_ext  = CW'(r_thresh);
        thr3     = thr_ext + (thr_ext << 1);
        elapsed  = r_now - r_win_start;
        xs_wide  = {r_xsum[31], r_xsum} + 33'(r_ax);
        if (xs_wide[32] != xs_wide[31]) begin
            xs_sat = xs_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            xs_sat = xs_wide[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay    <= DECAY_RST;
            r_thresh   <= THRESH_RST;
            r_window   <= WINDOW_RST;
            r_timeout  <= TIMEOUT_RST;
            r_cooldown <= COOLDOWN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DECAY:    r_decay    <= i_cfg_data[15:0];
                CFG_THRESH:   r_thresh   <= i_cfg_data[23:0];
                CFG_WINDOW:   r_window   <= i_cfg_data[15:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[15:0];
                CFG_COOLDOWN: r_cooldown <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have_prev  <= 1'b0;
            r_px         <= '0;
            r_py         <= '0;
            r_pz         <= '0;
            r_intensity  <= '0;
            r_phase      <= 1'b0;
            r_win_start  <= '0;
            r_xsum       <= '0;
            r_cool_until <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_xfer && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_ax  <= i_accel_x;
                        r_ay  <= i_accel_y;
                        r_az  <= i_accel_z;
                        r_now <= i_time_ms;
                        r_cnt <= '0;
                        r_state <= r_have_prev ? S_MUL : S_DEC;
                    end
                end
                S_MUL: begin
                    if (r_cnt == MUL_LAST) begin
                        r_decayed <= prod[IW+15:16];
                        r_rem     <= '0;
                        r_root    <= '0;
                        r_cnt     <= '0;
                        r_state   <= S_ROOT;
                    end else begin
                        r_sq  <= (r_cnt == '0) ? prod[SQ_W-1:0] : r_sq + prod[SQ_W-1:0];
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_ROOT: begin
                    r_sq   <= r_sq << 2;
                    r_rem  <= root_bit ? (RT_W + 2)'(rem_sh - trial) : (RT_W + 2)'(rem_sh);
                    r_root <= {r_root[RT_W-2:0], root_bit};
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == RT_LAST) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (upd_sum > SUM_W'({IW{1'b1}})) begin
                        r_intensity <= {IW{1'b1}};
                    end else begin
                        r_intensity <= upd_sum[IW-1:0];
                    end
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_px        <= r_ax;
                    r_py        <= r_ay;
                    r_pz        <= r_az;
                    r_have_prev <= 1'b1;
                    r_dir_pend  <= (r_now >= r_cool_until && r_phase
                                    && elapsed >= 32'(r_window))
                                   ? (xs_sat[31] ? DIR_LEFT : DIR_RIGHT) : DIR_NONE;
                    if (r_now < r_cool_until) begin
                        if (int10 < thr_ext) begin
                            r_intensity <= '0;
                        end
                    end else if (!r_phase) begin
                        if (int_ext > thr_ext) begin
                            r_phase     <= 1'b1;
                            r_win_start <= r_now;
                            r_xsum      <= '0;
                        end
                    end else begin
                        r_xsum <= xs_sat;
                        if (elapsed >= 32'(r_window)) begin
                            r_phase      <= 1'b0;
                            r_cool_until <= r_now + 32'(r_cooldown);
                            r_intensity  <= '0;
                        end else if (elapsed >= 32'(r_timeout) || int10 < thr3) begin
                            r_phase     <= 1'b0;
                            r_intensity <= '0;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_direction <= r_dir_pend;
                        r_detecting <= r_phase;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ISDD_ASSERT_NEXT(a_accept_busy, in_xfer, r_state != S_IDLE, "idle after input transfer")
    `ISDD_ASSERT(a_report_leaves, !(r_out_valid && r_direction != DIR_NONE && r_detecting),
        "direction reported while still detecting")
    `ISDD_ASSERT(a_dir_code, !(r_out_valid && r_direction == 2'sb10), "bad direction code")
    `ISDD_ASSERT_NEXT(a_out_load, r_state == S_OUT && (!r_out_valid || !i_out_stall),
        r_out_valid && r_state == S_IDLE, "result not loaded")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb
    import isdd_pkg::*;
();

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam longint unsigned LEVEL_MAX = (64'd1 << 24) - 64'd1;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    typedef struct {
        logic signed [1:0] dir;
        logic              det;
    } t_shake_result;

    class t_shake_scoreboard;
        logic [15:0]        decay_q16;
        logic [23:0]        trig_level;
        logic [15:0]        window_ms, timeout_ms, cool_ms;
        bit                 seen_prev;
        logic signed [15:0] last_x, last_y, last_z;
        longint unsigned    level;
        bit                 armed;
        logic [31:0]        win_t0, quiet_until;
        longint             sum_x;
        t_shake_result      want_q[$];
        int                 n_errors, n_checked, n_left, n_right, n_dropped;

        function new();
            decay_q16   = DECAY_RST;
            trig_level  = THRESH_RST;
            window_ms   = WINDOW_RST;
            timeout_ms  = TIMEOUT_RST;
            cool_ms     = COOLDOWN_RST;
            seen_prev   = 1'b0;
            last_x      = '0;
            last_y      = '0;
            last_z      = '0;
            level       = 0;
            armed       = 1'b0;
            win_t0      = '0;
            quiet_until = '0;
            sum_x       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DECAY:    decay_q16  = val[15:0];
                CFG_THRESH:   trig_level = val[23:0];
                CFG_WINDOW:   window_ms  = val[15:0];
                CFG_TIMEOUT:  timeout_ms = val[15:0];
                CFG_COOLDOWN: cool_ms    = val[15:0];
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r, t;
            r = 0;
            for (int b = 20; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= n)
                    r = t;
            end
            return r;
        endfunction

        function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                  logic signed [15:0] az, logic [31:0] now);
            longint          dx, dy, dz, s;
            longint unsigned grown;
            logic [31:0]     elapsed;
            t_shake_result   res;
            res.dir = DIR_NONE;
            if (seen_prev) begin
                dx = longint'(ax) - longint'(last_x);
                dy = longint'(ay) - longint'(last_y);
                dz = longint'(az) - longint'(last_z);
                grown = ((level * decay_q16) >> 16) + root_floor($unsigned(dx*dx + dy*dy + dz*dz));
                level = (grown > LEVEL_MAX) ? LEVEL_MAX : grown;
            end
            last_x    = ax;
            last_y    = ay;
            last_z    = az;
            seen_prev = 1'b1;

            if (now < quiet_until) begin
                if (level * 10 < trig_level)
                    level = 0;
            end else if (!armed) begin
                if (level > trig_level) begin
                    armed  = 1'b1;
                    win_t0 = now;
                    sum_x  = 0;
                end
            end else begin
                elapsed = now - win_t0;
                s = sum_x + longint'(ax);
                if (s > SUM_MAX)
                    s = SUM_MAX;
                else if (s < SUM_MIN)
                    s = SUM_MIN;
                sum_x = s;
                if (elapsed >= window_ms) begin
                    armed       = 1'b0;
                    quiet_until = now + cool_ms;
                    level       = 0;
                    if (sum_x < 0) begin
                        res.dir = DIR_LEFT;
                        n_left++;
                    end else begin
                        res.dir = DIR_RIGHT;
                        n_right++;
                    end
                end else if (elapsed >= timeout_ms || level * 10 < trig_level * 3) begin
                    armed = 1'b0;
                    level = 0;
                    n_dropped++;
                end
            end
            res.det = armed;
            want_q.push_back(res);
        endfunction

        function void check_result(logic signed [1:0] dir, logic det);
            t_shake_result want;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected result, direction %0d detecting %0d", $time, dir, det);
                n_errors++;
                return;
            end
            want = want_q.pop_front();
            n_checked++;
            if (dir !== want.dir) begin
                $display("%0t: direction expected %0d actual %0d", $time, want.dir, dir);
                n_errors++;
            end
            if (det !== want.det) begin
                $display("%0t: detecting expected %0d actual %0d", $time, want.det, det);
                n_errors++;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic signed [15:0]    i_accel_x   = '0;
    logic signed [15:0]    i_accel_y   = '0;
    logic signed [15:0]    i_accel_z   = '0;
    logic [31:0]           i_time_ms   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [1:0]     o_direction;
    logic                  o_detecting;

    t_shake_scoreboard sb = new();

    int          tx_idle_pct = 20;
    int          rx_idle_pct = 76;
    int          n_sent      = 0;
    int          n_cfg       = 0;
    int          cfg_mark    = 0;
    int          max_step_ms = 30;
    logic [31:0] clock_ms    = '0;
    logic [7:0]  hold_tag    = '0;
    logic [7:0]  hold_seen   = '0;
    int          hold_left   = 0;

    imu_shake_direction_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_time_ms   (i_time_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_direction (o_direction),
        .o_detecting (o_detecting)
    );

    always #10 i_clk = ~i_clk;

    // result side: check, then pick the stall for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_direction, o_detecting);
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic offer_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] az, logic [31:0] t_ms);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_x  <= ax;
        i_accel_y  <= ay;
        i_accel_z  <= az;
        i_time_ms  <= t_ms;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_sample(ax, ay, az, t_ms);
        n_sent++;
    endtask

    task automatic timed_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] az);
        clock_ms = clock_ms + $urandom_range(0, max_step_ms);
        offer_sample(ax, ay, az, clock_ms);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // upper data bits above a register's width are junk on purpose
    task automatic load_regs(logic [15:0] dcy, logic [23:0] thr, logic [15:0] win,
                             logic [15:0] tmo, logic [15:0] cool);
        settle();
        write_reg(CFG_DECAY,    {8'($urandom), dcy});
        write_reg(CFG_THRESH,   thr);
        write_reg(CFG_WINDOW,   {8'($urandom), win});
        write_reg(CFG_TIMEOUT,  {8'($urandom), tmo});
        write_reg(CFG_COOLDOWN, {8'($urandom), cool});
        write_reg(CFG_NONE,     24'($urandom));
        max_step_ms = 1 + (int'(win) + int'(cool) / 4) / 6;
        cfg_mark = n_sent;
        n_cfg++;
    endtask

    task automatic random_regs();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            load_regs(DECAY_RST, THRESH_RST, WINDOW_RST, TIMEOUT_RST, COOLDOWN_RST);
        else if (pick == 1)
            load_regs('0, '0, '0, '0, '0);
        else if (pick == 2)
            load_regs('1, '1, '1, '1, '1);
        else
            load_regs(16'($urandom_range(30000, 65535)), 24'($urandom_range(300, 30000)),
                      16'($urandom_range(20, 400)), 16'($urandom_range(30, 900)),
                      16'($urandom_range(0, 1000)));
    endtask

    // swings biased toward one X sign, then the device at rest
    task automatic shake_run(int bias, int n_swing, int n_rest);
        int sx;
        for (int k = 0; k < n_swing; k++) begin
            if (k % 2 == 0)
                sx = bias * int'($urandom_range(2000, 32767));
            else
                sx = -bias * int'($urandom_range(0, 12000));
            timed_sample(16'(sx), 16'($urandom), 16'($urandom));
        end
        for (int k = 0; k < n_rest; k++)
            timed_sample(16'(int'($urandom_range(0, 400)) - 200),
                         16'(int'($urandom_range(0, 400)) - 200),
                         16'(16184 + int'($urandom_range(0, 400))));
    endtask

    task automatic random_phase(int upto);
        int pick, bias, keep;
        while (n_sent < upto) begin
            if (n_sent - cfg_mark >= 110)
                random_regs();
            // a cooldown end that lies across the wrap would never come
            if (clock_ms < sb.quiet_until && sb.quiet_until - clock_ms > 32'd200000)
                clock_ms = sb.quiet_until;
            pick = $urandom_range(0, 99);
            bias = ($urandom_range(0, 1) != 0) ? 1 : -1;
            if (pick < 60) begin
                shake_run(bias, $urandom_range(4, 30), $urandom_range(3, 25));
            end else if (pick < 72) begin
                shake_run(bias, $urandom_range(1, 3), $urandom_range(3, 12));
            end else if (pick < 82) begin
                keep = max_step_ms;
                max_step_ms = keep * 8 + 50;
                shake_run(bias, $urandom_range(3, 12), 2);
                max_step_ms = keep;
            end else if (pick < 85) begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            end else begin
                keep = $urandom_range(3, 15);
                for (int k = 0; k < keep; k++)
                    if ($urandom_range(0, 1) != 0)
                        offer_sample(16'($urandom), 16'($urandom), 16'($urandom), $urandom());
                    else
                        timed_sample(16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: first sample, right report, cooldown, left report
        offer_sample(16'sh8000, 16'sh7FFF, 16'sd0, 32'd0);
        offer_sample(16'sh7FFF, 16'sh8000, 16'sh8000, 32'd10);
        offer_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'd20);
        offer_sample(16'sh7FFF, 16'sh8000, 16'sh8000, 32'd40);
        offer_sample(16'sh7FFF, 16'sd0, 16'sd16384, 32'd160);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'd200);
        offer_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd300);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'd559);
        offer_sample(-16'sd20000, 16'sd0, 16'sd16384, 32'd560);
        offer_sample(-16'sd30000, 16'sd5000, 16'sd0, 32'd600);
        offer_sample(16'sd20000, -16'sd5000, 16'sd16384, 32'd700);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'd710);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'd1110);

        // no decay: intensity drop abandons, then the timeout does
        load_regs(16'd0, THRESH_RST, WINDOW_RST, 16'd30, COOLDOWN_RST);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'd2000);
        offer_sample(16'sd5000, 16'sd0, 16'sd16384, 32'd2010);
        offer_sample(16'sd5000, 16'sd0, 16'sd16384, 32'd2020);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'd2030);
        offer_sample(16'sd5000, 16'sd0, 16'sd16384, 32'd2070);

        // zero window, longest cooldown, timestamps across the wrap
        load_regs(16'd0, THRESH_RST, 16'd0, 16'd30, 16'hFFFF);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'hFFFF_FFF0);
        offer_sample(-16'sd1, 16'sd0, 16'sd16384, 32'hFFFF_FFF8);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'h0000_0005);
        offer_sample(16'sd0, 16'sd0, 16'sd16384, 32'h0000_FFF7);
        clock_ms = 32'h0001_0000;

        load_regs('0, '0, '0, '0, '0);
        random_phase(500);

        settle();
        tx_idle_pct = 76;
        rx_idle_pct = 20;
        load_regs('1, '1, '1, '1, '1);
        random_phase(900);

        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // full swings drive intensity into saturation while the output backs up
        load_regs(16'hFFFF, 24'd16777214, 16'd200, 16'd400, 16'd100);
        max_step_ms = 1;
        hold_tag <= hold_tag + 8'd1;
        for (int k = 0; k < 170; k++)
            if (k % 2 == 0)
                timed_sample(16'sh8000, 16'sh8000, 16'sh8000);
            else
                timed_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        random_phase(1320);

        settle();
        $display("covered %0d samples under %0d register settings, %0d results checked",
                 n_sent, n_cfg, sb.n_checked);
        $display("shakes reported: %0d left, %0d right; %0d detections abandoned",
                 sb.n_left, sb.n_right, sb.n_dropped);
        if (sb.n_errors == 0)
            $display("imu_shake_direction_detector verification clean");
        else
            $display("imu_shake_direction_detector verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("imu_shake_direction_detector verification failed");
        $finish;
    end

endmodule
